// ===== rtl/rsti_pkg.sv =====
// shared constants, types and helpers for the radix string to integer converter
package rsti_pkg;

    localparam int MAX_SYMBOLS     = 16;
    localparam int SYMBOL_W        = 8;
    localparam int DIGIT_W         = $clog2(MAX_SYMBOLS);
    localparam int COUNT_W         = 5;
    localparam int ACC_W           = 32;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_INDEX_W     = 2;
    localparam int SYMBOLS_PER_REG = CFG_DATA_W / SYMBOL_W;

    localparam logic [CFG_INDEX_W-1:0] CFG_SYMBOLS_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYMBOLS_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIGIT_COUNT  = 2'd2;

    localparam logic [SYMBOL_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [SYMBOL_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [SYMBOL_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [SYMBOL_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [SYMBOL_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [SYMBOL_W-1:0] CHAR_MINUS = 8'h2D;

    typedef logic [MAX_SYMBOLS-1:0][SYMBOL_W-1:0] symbols_t;

    typedef struct packed {
        logic               hit;
        logic [DIGIT_W-1:0] digit;
    } digit_match_t;

    function automatic logic is_space(input logic [SYMBOL_W-1:0] c);
        return ((c >= CHAR_TAB) && (c <= CHAR_CR)) || (c == CHAR_SPACE);
    endfunction

endpackage

// ===== rtl/rsti_digit_lookup.sv =====
// maps a character to its digit value in the configured alphabet
module rsti_digit_lookup import rsti_pkg::*;
(
    input  logic [SYMBOL_W-1:0] char_code,
    input  symbols_t            symbols,
    input  logic [COUNT_W-1:0]  radix,
    output digit_match_t        match
);

    // descending scan so the lowest matching index wins
    always_comb
    begin
        match.hit   = 1'b0;
        match.digit = '0;
        for (int i = MAX_SYMBOLS - 1; i >= 0; i--)
        begin
            if ((COUNT_W'(i) < radix) && (symbols[i] == char_code))
            begin
                match.hit   = 1'b1;
                match.digit = DIGIT_W'(i);
            end
        end
    end

endmodule

// ===== rtl/rsti_alphabet_check.sv =====
// checks the configured alphabet for size, reserved symbols and duplicates
module rsti_alphabet_check import rsti_pkg::*;
(
    input  symbols_t           symbols,
    input  logic [COUNT_W-1:0] count,
    output logic               valid
);

    logic [MAX_SYMBOLS-1:0] sym_bad;

    always_comb
    begin
        for (int i = 0; i < MAX_SYMBOLS; i++)
        begin
            sym_bad[i] = 1'b0;
            if (COUNT_W'(i) < count)
            begin
                sym_bad[i] = (symbols[i] == CHAR_NUL) || (symbols[i] == CHAR_PLUS) ||
                             (symbols[i] == CHAR_MINUS) || is_space(symbols[i]);
                for (int j = i + 1; j < MAX_SYMBOLS; j++)
                begin
                    if ((COUNT_W'(j) < count) && (symbols[j] == symbols[i]))
                    begin
                        sym_bad[i] = 1'b1;
                    end
                end
            end
        end
    end

    assign valid = (count >= COUNT_W'(2)) && (count <= COUNT_W'(MAX_SYMBOLS)) &&
                   (sym_bad == '0);

endmodule

// ===== rtl/radix_string_to_integer.sv =====
// top level of the radix string to integer converter
// Converts a character stream to a signed 32-bit integer, one character word per cycle. Leading
// whitespace is skipped, a run of '+'/'-' sets the sign, and the rest must be symbols of the
// alphabet written through the configuration port (digit_count symbols, its radix). A NUL
// character ends the string; its value word is registered in the result register after the NUL has
// passed the input register, and is 0 on any bad character or bad alphabet. The block sustains one
// character per cycle; each character goes through one input register and then alphabet match,
// multiply by the radix and add, which set the cycle time. A held result stalls input only
// while the next NUL waits in the input register. Alphabet validity is registered from the
// configuration registers, so it follows a configuration write through one more register.
module radix_string_to_integer import rsti_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SYMBOL_W-1:0]    char_code,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic signed [ACC_W-1:0] value,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [1:0] PH_SPACE = 2'd0;
    localparam logic [1:0] PH_SIGN  = 2'd1;
    localparam logic [1:0] PH_DIGIT = 2'd2;

    logic [CFG_DATA_W-1:0] sym_low_reg, sym_high_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic                  alpha_valid_reg, alpha_valid;

    logic                  s1_valid_reg, s1_valid_next;
    logic [SYMBOL_W-1:0]   s1_char_reg;

    logic [1:0]            phase_reg, phase_next;
    logic                  negative_reg, negative_next;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    logic                  failed_reg, failed_next;

    logic                  out_valid_reg, out_valid_next;
    logic [ACC_W-1:0]      value_reg, value_next;

    symbols_t              symbols;
    logic [COUNT_W-1:0]    radix;
    digit_match_t          match;
    logic [ACC_W+COUNT_W-1:0] mul_full;
    logic                  s1_term, s1_fire, out_free;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sym_low_reg     <= '0;
            sym_high_reg    <= '0;
            count_reg       <= '0;
            alpha_valid_reg <= 1'b0;
        end
        else
        begin
            alpha_valid_reg <= alpha_valid;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_SYMBOLS_LOW:  sym_low_reg  <= cfg_data;
                    CFG_SYMBOLS_HIGH: sym_high_reg <= cfg_data;
                    CFG_DIGIT_COUNT:  count_reg    <= cfg_data[COUNT_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    // symbol k sits in byte k of the two symbol registers taken together
    assign symbols = {sym_high_reg, sym_low_reg};

    assign radix = (count_reg > COUNT_W'(MAX_SYMBOLS)) ? COUNT_W'(MAX_SYMBOLS) : count_reg;

    rsti_alphabet_check u_alpha
    (
        .symbols (symbols),
        .count   (count_reg),
        .valid   (alpha_valid)
    );

    rsti_digit_lookup u_lookup
    (
        .char_code (s1_char_reg),
        .symbols   (symbols),
        .radix     (radix),
        .match     (match)
    );

    // handshake: only a terminator needs room in the result register
    assign s1_term  = (s1_char_reg == CHAR_NUL);
    assign out_free = !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && (!s1_term || out_free);
    assign in_ready = !s1_valid_reg || s1_fire;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_ready)
            s1_valid_next = in_valid;
    end

    assign mul_full = {{COUNT_W{1'b0}}, acc_reg} * {{ACC_W{1'b0}}, radix};

    always_comb
    begin
        phase_next     = phase_reg;
        negative_next  = negative_reg;
        acc_next       = acc_reg;
        failed_next    = failed_reg;
        out_valid_next = out_valid_reg;
        value_next     = value_reg;

        if (out_ready)
            out_valid_next = 1'b0;

        if (s1_fire)
        begin
            priority if (s1_term)
            begin
                out_valid_next = 1'b1;
                value_next     = '0;
                if (!failed_reg && alpha_valid_reg)
                    value_next = negative_reg ? (ACC_W'(0) - acc_reg) : acc_reg;
                phase_next    = PH_SPACE;
                negative_next = 1'b0;
                acc_next      = '0;
                failed_next   = 1'b0;
            end
            else if ((phase_reg == PH_SPACE) && is_space(s1_char_reg))
            begin
                phase_next = PH_SPACE;
            end
            else if (((phase_reg == PH_SPACE) || (phase_reg == PH_SIGN)) &&
                     ((s1_char_reg == CHAR_PLUS) || (s1_char_reg == CHAR_MINUS)))
            begin
                phase_next = PH_SIGN;
                if (s1_char_reg == CHAR_MINUS)
                    negative_next = !negative_reg;
            end
            else
            begin
                phase_next = PH_DIGIT;
                if (match.hit)
                    acc_next = mul_full[ACC_W-1:0] + {{(ACC_W-DIGIT_W){1'b0}}, match.digit};
                else
                    failed_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            phase_reg     <= PH_SPACE;
            negative_reg  <= 1'b0;
            acc_reg       <= '0;
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            phase_reg     <= phase_next;
            negative_reg  <= negative_next;
            acc_reg       <= acc_next;
            failed_reg    <= failed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_char_reg <= char_code;
        value_reg <= value_next;
    end

    assign out_valid = out_valid_reg;
    assign value     = signed'(value_reg);

`ifndef NO_ASSERTIONS
    a_clear_after_term: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_term) |=> ((phase_reg == PH_SPACE) && !negative_reg &&
                                  (acc_reg == '0) && !failed_reg))
        else $error("string state not cleared after terminator");

    a_result_from_term: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg && (s1_char_reg == CHAR_NUL)))
        else $error("result word not caused by a terminator");

    a_failed_in_digits: assert property (@(posedge clk) disable iff (!rst_n)
        failed_reg |-> (phase_reg == PH_DIGIT))
        else $error("failure flagged outside the digit run");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && s1_term && out_valid_reg && !out_ready))
        else $error("input stalled without a blocked terminator");
`endif

endmodule

// ===== verif/testbench.sv =====
// testbench for the radix string to integer converter: value scoreboard, drivers and stimulus
module testbench import rsti_pkg::*;
;

    localparam int PERIOD          = 8;
    localparam int RESET_CYCLES    = 12;
    localparam int IDLE_PCT        = 31;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DRAIN_CYCLES    = 10;
    localparam int HOLD_CYCLES     = 200;
    localparam int CYCLE_LIMIT     = 100000;
    localparam int REPORT_LIMIT    = 10;
    localparam int RANDOM_ITEMS    = 400;
    localparam int WELL_FORMED_PCT = 70;
    localparam int BROKEN_PCT      = 85;
    localparam int FAULT_PCT       = 40;
    localparam int PRESSURE_PHASE  = 3;
    localparam int STEADY_PHASE    = 5;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum logic [1:0] {SCAN_BLANKS, SCAN_SIGNS, SCAN_DIGITS} scan_t;
    typedef enum int {BAD_SHORT, BAD_LONG, BAD_DUP, BAD_SIGN, BAD_BLANK, BAD_NUL, BAD_ONES}
        alpha_fault_t;

    class value_predictor;
        logic [CFG_DATA_W-1:0] symbols_lo;
        logic [CFG_DATA_W-1:0] symbols_hi;
        logic [COUNT_W-1:0]    radix;
        scan_t                 scan;
        bit                    negative;
        bit                    failed;
        logic [ACC_W-1:0]      acc;
        logic [ACC_W-1:0]      expected_values[$];
        int                    values_checked;
        int                    errors;

        function new();
            symbols_lo     = '0;
            symbols_hi     = '0;
            radix          = '0;
            values_checked = 0;
            errors         = 0;
            restart();
        endfunction

        function void restart();
            scan     = SCAN_BLANKS;
            negative = 1'b0;
            failed   = 1'b0;
            acc      = '0;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SYMBOLS_LOW:  symbols_lo = data;
                CFG_SYMBOLS_HIGH: symbols_hi = data;
                CFG_DIGIT_COUNT:  radix = data[COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [SYMBOL_W-1:0] symbol(int k);
            logic [CFG_DATA_W-1:0] w;
            w = (k < SYMBOLS_PER_REG) ? symbols_lo : symbols_hi;
            return w[(k % SYMBOLS_PER_REG) * SYMBOL_W +: SYMBOL_W];
        endfunction

        function bit blank(logic [SYMBOL_W-1:0] c);
            return (c >= CHAR_TAB && c <= CHAR_CR) || c == CHAR_SPACE;
        endfunction

        function int radix_used();
            return (radix > MAX_SYMBOLS) ? MAX_SYMBOLS : int'(radix);
        endfunction

        function bit alphabet_ok();
            logic [SYMBOL_W-1:0] s;
            if (radix < 2 || radix > MAX_SYMBOLS)
                return 1'b0;
            for (int i = 0; i < radix; i++)
            begin
                s = symbol(i);
                if (s == CHAR_NUL || s == CHAR_PLUS || s == CHAR_MINUS || blank(s))
                    return 1'b0;
                for (int j = i + 1; j < radix; j++)
                    if (symbol(j) == s)
                        return 1'b0;
            end
            return 1'b1;
        endfunction

        // called for every accepted character word
        function void take_char(logic [SYMBOL_W-1:0] c);
            int d;
            int n;
            if (c == CHAR_NUL)
            begin
                if (failed || !alphabet_ok())
                    expected_values.push_back('0);
                else
                    expected_values.push_back(negative ? -acc : acc);
                restart();
                return;
            end
            if (scan == SCAN_BLANKS)
            begin
                if (blank(c))
                    return;
                scan = SCAN_SIGNS;
            end
            if (scan == SCAN_SIGNS)
            begin
                if (c == CHAR_PLUS || c == CHAR_MINUS)
                begin
                    if (c == CHAR_MINUS)
                        negative = !negative;
                    return;
                end
                scan = SCAN_DIGITS;
            end
            // first matching symbol wins
            d = -1;
            n = radix_used();
            for (int i = 0; i < n; i++)
                if (d < 0 && symbol(i) == c)
                    d = i;
            if (d < 0)
                failed = 1'b1;
            else
                acc = acc * ACC_W'(n) + ACC_W'(d);
        endfunction

        function void match_value(logic [ACC_W-1:0] got);
            logic [ACC_W-1:0] want;
            values_checked++;
            if (expected_values.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("value %0d arrived with none expected", $signed(got));
                return;
            end
            want = expected_values.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("value mismatch: expected %0d, got %0d",
                             $signed(want), $signed(got));
            end
        endfunction

        function int pending();
            return expected_values.size();
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic [SYMBOL_W-1:0]     char_code;
    logic                    out_valid;
    logic                    out_ready;
    logic signed [ACC_W-1:0] value;
    logic                    cfg_write;
    logic [CFG_INDEX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    value_predictor values = new();
    logic [SYMBOL_W-1:0] alpha [MAX_SYMBOLS];
    int alpha_count   = 0;
    bit gaps_on       = 1'b1;
    bit hold_req      = 1'b0;
    int chars_sent    = 0;
    int settings_used = 0;
    int cycle_count   = 0;

    radix_string_to_integer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .char_code (char_code),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value     (value),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    task automatic send_char(input logic [SYMBOL_W-1:0] c);
        if (gaps_on && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while (gaps_on && $urandom_range(99) < IDLE_PCT);
        end
        in_valid  <= 1'b1;
        char_code <= c;
        do
            @(posedge clk);
        while (!in_ready);
        values.take_char(c);
        chars_sent++;
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    // wait until every value is back and the pipeline is empty
    task automatic settle();
        in_valid <= 1'b0;
        while (values.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        values.set_reg(idx, data);
    endtask

    task automatic end_writes();
        cfg_write <= 1'b0;
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_alphabet(input int count);
        logic [2*CFG_DATA_W-1:0] packed_syms;
        for (int k = 0; k < MAX_SYMBOLS; k++)
            packed_syms[k*SYMBOL_W +: SYMBOL_W] = alpha[k];
        write_reg(CFG_SYMBOLS_LOW, packed_syms[CFG_DATA_W-1:0]);
        write_reg(CFG_SYMBOLS_HIGH, packed_syms[2*CFG_DATA_W-1:CFG_DATA_W]);
        write_reg(CFG_DIGIT_COUNT, CFG_DATA_W'(count));
        alpha_count = count;
        settings_used++;
    endtask

    task automatic set_text_alphabet(input string s, input int count);
        for (int k = 0; k < MAX_SYMBOLS; k++)
            alpha[k] = (k < s.len()) ? s[k] : CHAR_NUL;
        load_alphabet(count);
        end_writes();
    endtask

    function automatic logic [SYMBOL_W-1:0] blank_char();
        int b;
        b = $urandom_range(5);
        return (b == 5) ? CHAR_SPACE : CHAR_TAB + SYMBOL_W'(b);
    endfunction

    function automatic bit reserved_char(logic [SYMBOL_W-1:0] c);
        return c == CHAR_PLUS || c == CHAR_MINUS || c == CHAR_SPACE ||
               (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    // distinct usable symbols, sometimes spoiled by one fault
    task automatic pick_random_alphabet();
        int n;
        bit clash;
        logic [SYMBOL_W-1:0] c;
        alpha_fault_t fault;
        for (int k = 0; k < MAX_SYMBOLS; k++)
            alpha[k] = SYMBOL_W'($urandom_range(255));
        n = $urandom_range(MAX_SYMBOLS, 2);
        for (int k = 0; k < n; k++)
        begin
            do
            begin
                c = SYMBOL_W'($urandom_range(255, 1));
                clash = reserved_char(c);
                for (int j = 0; j < k; j++)
                    if (alpha[j] == c)
                        clash = 1'b1;
            end
            while (clash);
            alpha[k] = c;
        end
        if ($urandom_range(99) < FAULT_PCT)
        begin
            fault = alpha_fault_t'($urandom_range(BAD_ONES));
            case (fault)
                BAD_SHORT: n = $urandom_range(1);
                BAD_LONG:  n = ($urandom_range(1) != 0) ? 31 : $urandom_range(30, 17);
                BAD_DUP:   alpha[$urandom_range(n - 1, 1)] = alpha[0];
                BAD_SIGN:  alpha[$urandom_range(n - 1)] =
                               ($urandom_range(1) != 0) ? CHAR_PLUS : CHAR_MINUS;
                BAD_BLANK: alpha[$urandom_range(n - 1)] = blank_char();
                BAD_NUL:   alpha[$urandom_range(n - 1)] = CHAR_NUL;
                BAD_ONES:
                begin
                    n = MAX_SYMBOLS;
                    for (int k = 0; k < MAX_SYMBOLS; k++)
                        alpha[k] = '1;
                end
                default: ;
            endcase
        end
        load_alphabet(n);
        end_writes();
    endtask

    function automatic logic [SYMBOL_W-1:0] digit_char();
        int n;
        logic [SYMBOL_W-1:0] c;
        n = (alpha_count > MAX_SYMBOLS) ? MAX_SYMBOLS : alpha_count;
        if (n == 0)
            return SYMBOL_W'($urandom_range(255, 1));
        c = alpha[$urandom_range(n - 1)];
        // a nul symbol cannot be sent as a digit, it would end the string
        return (c == CHAR_NUL) ? SYMBOL_W'($urandom_range(255, 1)) : c;
    endfunction

    task automatic send_number();
        int shape;
        int digits;
        int spoil;
        shape = $urandom_range(99);
        if (shape >= BROKEN_PCT)
        begin
            repeat ($urandom_range(8)) send_char(SYMBOL_W'($urandom_range(255, 1)));
        end
        else
        begin
            digits = ($urandom_range(9) == 0) ? $urandom_range(14, 9) : $urandom_range(8, 1);
            spoil  = (shape >= WELL_FORMED_PCT) ? int'($urandom_range(digits - 1)) : -1;
            repeat ($urandom_range(3)) send_char(blank_char());
            repeat ($urandom_range(3))
                send_char(($urandom_range(1) != 0) ? CHAR_PLUS : CHAR_MINUS);
            for (int k = 0; k < digits; k++)
            begin
                if (k == spoil)
                    send_char(($urandom_range(1) != 0) ?
                              SYMBOL_W'($urandom_range(255, 1)) : CHAR_MINUS);
                send_char(digit_char());
            end
        end
        send_char(CHAR_NUL);
    endtask

    // result side: random back-pressure plus one long hold-off on request
    initial
    begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                values.match_value(value);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_ready <= !gaps_on || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial
    begin
        int phase;
        int budget;
        int random_start;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        char_code <= '0;
        cfg_write <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset alphabet is empty, so any string gives zero
        send_char(CHAR_NUL);
        settle();
        set_text_alphabet("0123456789", 10);
        send_char(CHAR_TAB);
        send_char(CHAR_CR);
        send_char(CHAR_SPACE);
        send_str("-+--9");
        send_char(CHAR_NUL);
        // sign run with no digits
        send_str("-");
        send_char(CHAR_NUL);
        // sign inside the digit run
        send_str("1-");
        send_char(CHAR_NUL);
        send_str("7");
        send_char('1);
        send_char(CHAR_NUL);
        // alphabet swapped in the middle of a string, plus a write to a missing register
        send_str("1");
        settle();
        set_text_alphabet("0123456789abcdef", 16);
        write_reg(CFG_UNUSED, '1);
        end_writes();
        send_str("f");
        send_char(CHAR_NUL);
        settle();
        set_text_alphabet("01234560", 8);
        send_str("5");
        send_char(CHAR_NUL);

        random_start = chars_sent;
        phase = 0;
        while (chars_sent - random_start < RANDOM_ITEMS)
        begin
            settle();
            if (phase == 0)
                set_text_alphabet("01", 2);
            else if (phase == 1)
                set_text_alphabet("0123456789ABCDEF", 16);
            else if (phase == 2)
                set_text_alphabet("0123456789", 10);
            else
                pick_random_alphabet();
            gaps_on = (phase != STEADY_PHASE);
            if (phase == PRESSURE_PHASE)
            begin
                hold_req = 1'b1;
                budget = chars_sent + 60;
            end
            else
                budget = chars_sent + $urandom_range(50, 25);
            while (chars_sent < budget)
                send_number();
            phase++;
        end

        in_valid <= 1'b0;
        while (values.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("sent %0d characters over %0d alphabet settings, %0d values checked",
                 chars_sent, settings_used, values.values_checked);
        $display("%0d mismatching values", values.errors);
        if (values.errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/rsti_pkg.sv
rtl/rsti_digit_lookup.sv
rtl/rsti_alphabet_check.sv
rtl/radix_string_to_integer.sv
verif/testbench.sv
